// ===== src/bei_pkg.sv =====
// ============================================================================
// bei_pkg: shared constants and types of the bounce easing interpolator
// Fixed-point formats, bounce segment constants and blend mode codes.
// ============================================================================
package bei_pkg;

  // Field widths.
  localparam int TimeW = 17;   // unsigned Q1.16 time
  localparam int PosW  = 24;   // signed Q16.8 position
  localparam int DiffW = PosW + 1;
  localparam int HW    = 18;   // blend factor, unsigned Q1.17
  localparam int MagW  = 20;   // magnitude of the segment offset term
  localparam int SqW   = 2 * MagW;
  localparam int ProdW = HW + 1 + DiffW;

  // One and one half in Q1.16.
  localparam logic [TimeW-1:0] OneQ16  = 17'd65536;
  localparam logic [TimeW-1:0] HalfQ16 = 17'd32768;

  // Segment limits 4/11, 8/11 and 10/11 compared as 11*x against k*2^16.
  localparam logic [19:0] Lim1 = 20'(4 * 65536);
  localparam logic [19:0] Lim2 = 20'(8 * 65536);
  localparam logic [19:0] Lim3 = 20'(10 * 65536);

  // Segment centers scaled by 22 (so that n1*(x-off)^2 = d^2 / 2^38).
  localparam logic [20:0] Ctr1 = 21'(12 * 65536);
  localparam logic [20:0] Ctr2 = 21'(18 * 65536);
  localparam logic [20:0] Ctr3 = 21'(21 * 65536);

  // Curve offsets 0.75, 0.9375 and 0.984375 in Q0.16.
  localparam logic [TimeW-1:0] Off1 = 17'd49152;
  localparam logic [TimeW-1:0] Off2 = 17'd61440;
  localparam logic [TimeW-1:0] Off3 = 17'd64512;

  // Rounding constants.
  localparam logic [SqW-1:0]   SqRound   = SqW'(64'd1 << 21);
  localparam logic signed [ProdW-1:0] ProdRound = ProdW'(65536);

  // Saturation limits of the position range.
  localparam logic signed [PosW+3:0] PosMax = 28'sd8388607;
  localparam logic signed [PosW+3:0] PosMin = -28'sd8388608;

  // Blend modes.
  localparam logic [1:0] ModeOut  = 2'd0;  // ease-out: H = 2B(t)
  localparam logic [1:0] ModeLow  = 2'd1;  // in-out, first half
  localparam logic [1:0] ModeHigh = 2'd2;  // in-out, second half

  // Pipeline control handed to every stage.
  typedef struct packed {
    logic en;
  } bei_ctl_t;

endpackage

// ===== src/bounce_easing_interpolator_core.sv =====
// ============================================================================
// bounce_easing_interpolator_core: eased 2D position from time and endpoints
// Requests pass the curve stages, the lane product and the output register.
// Throughput: one request per cycle; the whole pipeline advances together and
// holds only while the output register waits on out_ready_i.
// Reset: rst_ni clears the valid bits of all stages; no clearing pass.
// ============================================================================
module bounce_easing_interpolator_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             kind_i,
  input  logic [bei_pkg::TimeW-1:0]        time_req_i,
  input  logic signed [bei_pkg::PosW-1:0]  start_u_i,
  input  logic signed [bei_pkg::PosW-1:0]  start_v_i,
  input  logic signed [bei_pkg::PosW-1:0]  end_u_i,
  input  logic signed [bei_pkg::PosW-1:0]  end_v_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [bei_pkg::PosW-1:0]  pos_u_o,
  output logic signed [bei_pkg::PosW-1:0]  pos_v_o
);
  import bei_pkg::*;

  bei_ctl_t               ctl;
  logic [HW-1:0]          h;
  logic [3:0]             v_q;
  logic                   out_valid_q;
  logic signed [PosW-1:0] lane_u, lane_v;
  logic signed [PosW-1:0] pos_u_q, pos_v_q;

  // The pipeline moves whenever the output register is free or being read.
  assign ctl.en     = !out_valid_q || out_ready_i;
  assign in_ready_o = ctl.en;

  bei_curve u_curve (
    .clk_i      (clk_i),
    .ctl_i      (ctl),
    .kind_i     (kind_i),
    .time_req_i (time_req_i),
    .h_o        (h)
  );

  bei_lane u_lane_u (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .start_i (start_u_i),
    .end_i   (end_u_i),
    .h_i     (h),
    .pos_o   (lane_u)
  );

  bei_lane u_lane_v (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .start_i (start_v_i),
    .end_i   (end_v_i),
    .h_i     (h),
    .pos_o   (lane_v)
  );

  // Valid bits of the four inner stages and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else if (ctl.en) begin
      v_q         <= {v_q[2:0], in_valid_i};
      out_valid_q <= v_q[3];
    end
  end

  // Output register merges both lanes into one result.
  always_ff @(posedge clk_i) begin
    if (ctl.en) begin
      pos_u_q <= lane_u;
      pos_v_q <= lane_v;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_u_o     = pos_u_q;
  assign pos_v_o     = pos_v_q;

endmodule

// ===== src/bei_curve.sv =====
// ============================================================================
// bei_curve: bounce curve and blend factor
// Three pipeline stages from time and mode to the Q1.17 blend factor H.
// ============================================================================
module bei_curve (
  input  logic                          clk_i,
  input  bei_pkg::bei_ctl_t             ctl_i,
  input  logic                          kind_i,
  input  logic [bei_pkg::TimeW-1:0]     time_req_i,
  output logic [bei_pkg::HW-1:0]        h_o
);
  import bei_pkg::*;

  logic [TimeW-1:0] tsat;
  logic [1:0]       mode;
  logic [TimeW:0]   two_t;
  logic [TimeW:0]   x18;
  logic [TimeW-1:0] x;
  logic [19:0]      x11;
  logic [20:0]      x22;
  logic [20:0]      ctr;
  logic [TimeW-1:0] off;
  logic signed [21:0] d;
  logic [21:0]      mag_full;

  logic [MagW-1:0]  mag_q;
  logic [1:0]       mode1_q, mode2_q;
  logic [TimeW-1:0] off1_q, off2_q;
  logic [SqW-1:0]   sq_q;
  logic [TimeW-1:0] b;
  logic [HW-1:0]    h_d, h_q;

  // Saturate time, pick the mode and form the curve argument.
  always_comb begin
    tsat  = (time_req_i > OneQ16) ? OneQ16 : time_req_i;
    two_t = {tsat, 1'b0};
    if (!kind_i) begin
      mode = ModeOut;
      x18  = {1'b0, tsat};
    end else if (tsat < HalfQ16) begin
      mode = ModeLow;
      x18  = {1'b0, OneQ16} - two_t;
    end else begin
      mode = ModeHigh;
      x18  = two_t - {1'b0, OneQ16};
    end
    x = x18[TimeW-1:0];
  end

  // Segment select and offset term d = 22x - center.
  always_comb begin
    x11 = (20'(x) << 3) + (20'(x) << 1) + 20'(x);
    x22 = {x11, 1'b0};
    if (x11 < Lim1) begin
      ctr = '0;
      off = '0;
    end else if (x11 < Lim2) begin
      ctr = Ctr1;
      off = Off1;
    end else if (x11 < Lim3) begin
      ctr = Ctr2;
      off = Off2;
    end else begin
      ctr = Ctr3;
      off = Off3;
    end
    d        = $signed({1'b0, x22}) - $signed({1'b0, ctr});
    mag_full = d[21] ? 22'(-d) : 22'(d);
  end

  // Stage 1: offset magnitude and segment data.
  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      mag_q   <= mag_full[MagW-1:0];
      mode1_q <= mode;
      off1_q  <= off;
    end
  end

  // Stage 2: square of the offset term.
  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      sq_q    <= mag_q * mag_q;
      mode2_q <= mode1_q;
      off2_q  <= off1_q;
    end
  end

  // Round the square into Q0.16 and form the blend factor.
  always_comb begin
    b = TimeW'((sq_q + SqRound) >> 22) + off2_q;
    unique case (mode2_q)
      ModeOut:  h_d = {b, 1'b0};
      ModeLow:  h_d = HW'(OneQ16) - HW'(b);
      ModeHigh: h_d = HW'(OneQ16) + HW'(b);
      default:  h_d = '0;
    endcase
  end

  // Stage 3: blend factor.
  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      h_q <= h_d;
    end
  end

  assign h_o = h_q;

endmodule

// ===== src/bei_lane.sv =====
// ============================================================================
// bei_lane: one coordinate lane of the blend
// Delays start and difference to meet H, multiplies, rounds and saturates.
// ============================================================================
module bei_lane (
  input  logic                               clk_i,
  input  bei_pkg::bei_ctl_t                  ctl_i,
  input  logic signed [bei_pkg::PosW-1:0]    start_i,
  input  logic signed [bei_pkg::PosW-1:0]    end_i,
  input  logic [bei_pkg::HW-1:0]             h_i,
  output logic signed [bei_pkg::PosW-1:0]    pos_o
);
  import bei_pkg::*;

  logic signed [PosW-1:0]  s_q [4];
  logic signed [DiffW-1:0] diff_q [3];
  logic signed [DiffW-1:0] diff;
  logic signed [ProdW-1:0] prod_q;
  logic signed [ProdW-1:0] sum;
  logic signed [PosW+2:0]  quo;
  logic signed [PosW+3:0] r;

  assign diff = $signed({end_i[PosW-1], end_i}) - $signed({start_i[PosW-1], start_i});

  // Start and difference travel beside the curve stages.
  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      s_q[0]    <= start_i;
      diff_q[0] <= diff;
      s_q[1]    <= s_q[0];
      diff_q[1] <= diff_q[0];
      s_q[2]    <= s_q[1];
      diff_q[2] <= diff_q[1];
      s_q[3]    <= s_q[2];
      prod_q    <= $signed({1'b0, h_i}) * diff_q[2];
    end
  end

  // Round to nearest (ties upward), add the start and saturate.
  always_comb begin
    sum = prod_q + ProdRound;
    quo = sum[ProdW-1:17];
    r   = $signed({{4{s_q[3][PosW-1]}}, s_q[3]}) + $signed({quo[PosW+2], quo});
    if (r > PosMax) begin
      pos_o = PosMax[PosW-1:0];
    end else if (r < PosMin) begin
      pos_o = PosMin[PosW-1:0];
    end else begin
      pos_o = r[PosW-1:0];
    end
  end

endmodule

// ===== src/bei_checker.sv =====
// ============================================================================
// bei_checker: port-level checks of the interpolator
// Watches the handshakes of the top level and is bound to it below.
// ============================================================================
module bei_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_ready_o,
  input  logic                             out_valid_o,
  input  logic                             out_ready_i,
  input  logic signed [bei_pkg::PosW-1:0]  pos_u_o,
  input  logic signed [bei_pkg::PosW-1:0]  pos_v_o
);

  // A stalled result keeps its valid and its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pos_u_o) && $stable(pos_v_o))
    else $error("stalled result changed");

  // A waiting request is not withdrawn before it is taken.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i)
    else $error("request withdrawn while waiting");

  // New requests are refused only while a finished result waits.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("ready does not follow output stall");

  // Right after reset no result is shown.
  a_reset: assert property (@(posedge clk_i)
    !$past(rst_ni) |-> !out_valid_o)
    else $error("result valid right after reset");

endmodule

bind bounce_easing_interpolator_core bei_checker u_bei_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .pos_u_o     (pos_u_o),
  .pos_v_o     (pos_v_o)
);

// ===== verif/testbench.sv =====
// ============================================================================
// testbench: self-checking bench for bounce_easing_interpolator_core
// Streams eased-position requests through the core with random gaps and
// output stalls. Each accepted request is predicted in fixed point, and each
// result is checked in order against the oldest expected position.
// ============================================================================
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bei_pkg::*;

  localparam int RandomReqs = 1250;
  localparam int CycleLimit = 400000;
  localparam int DrainLatency = 20;
  // The sender waits for an empty pipeline before these request counts.
  localparam int DrainFirst = 20;
  localparam int DrainSecond = 700;
  // Neither side idles while the accepted count is inside this window.
  localparam int CalmStart = 450;
  localparam int CalmEnd = 700;

  typedef enum logic {
    KindOut   = 1'b0,
    KindInOut = 1'b1
  } ease_kind_e;

  typedef struct packed {
    ease_kind_e             kind;
    logic [TimeW-1:0]       progress;
    logic signed [PosW-1:0] start_u;
    logic signed [PosW-1:0] start_v;
    logic signed [PosW-1:0] end_u;
    logic signed [PosW-1:0] end_v;
  } ease_req_t;

  typedef struct packed {
    logic signed [PosW-1:0] u;
    logic signed [PosW-1:0] v;
  } ease_pos_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   out_ready_i = 1'b0;
  ease_req_t              cur_req = '0;
  logic                   in_ready_o;
  logic                   out_valid_o;
  logic signed [PosW-1:0] pos_u_o;
  logic signed [PosW-1:0] pos_v_o;

  ease_req_t req_backlog[$];
  ease_pos_t pos_expected[$];

  int  total_reqs = 0;
  int  accepted_cnt = 0;
  int  checked_cnt = 0;
  int  error_cnt = 0;
  int  cycle_cnt = 0;
  int  out_kind_cnt = 0;
  int  inout_kind_cnt = 0;
  int  clipped_time_cnt = 0;
  bit  req_taken = 1'b0;

  bounce_easing_interpolator_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (cur_req.kind),
    .time_req_i  (cur_req.progress),
    .start_u_i   (cur_req.start_u),
    .start_v_i   (cur_req.start_v),
    .end_u_i     (cur_req.end_u),
    .end_v_i     (cur_req.end_v),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pos_u_o     (pos_u_o),
    .pos_v_o     (pos_v_o)
  );

  always #10 clk_i = ~clk_i;

  // Bounce curve in Q0.16. The segment is chosen by comparing 11*x against
  // 4, 8 and 10 times one, and the square is rounded to nearest.
  function automatic longint bounce_curve_q16(longint x);
    longint center;
    longint offset;
    longint d;
    if (11 * x < 4 * 65536) begin
      center = 0;
      offset = 0;
    end else if (11 * x < 8 * 65536) begin
      center = 12;
      offset = 49152;
    end else if (11 * x < 10 * 65536) begin
      center = 18;
      offset = 61440;
    end else begin
      center = 21;
      offset = 64512;
    end
    d = 22 * x - center * 65536;
    if (d < 0) d = -d;
    return ((d * d + (64'sd1 <<< 21)) >>> 22) + offset;
  endfunction

  // One coordinate: start plus the rounded, Q1.17-scaled difference, clipped.
  function automatic logic signed [PosW-1:0] blend_axis(longint factor,
                                                       logic signed [PosW-1:0] s,
                                                       logic signed [PosW-1:0] e);
    longint diff;
    longint pos;
    diff = longint'(e) - longint'(s);
    pos = longint'(s) + ((factor * diff + 65536) >>> 17);
    if (pos > 8388607) pos = 8388607;
    if (pos < -8388608) pos = -8388608;
    return PosW'(pos);
  endfunction

  // Eased position for one request.
  function automatic ease_pos_t predict_position(ease_req_t r);
    longint t;
    longint factor;
    ease_pos_t p;
    t = longint'(r.progress);
    if (t > 65536) t = 65536;
    if (r.kind == KindOut) begin
      factor = 2 * bounce_curve_q16(t);
    end else if (t < 32768) begin
      factor = 65536 - bounce_curve_q16(65536 - 2 * t);
    end else begin
      factor = 65536 + bounce_curve_q16(2 * t - 65536);
    end
    p.u = blend_axis(factor, r.start_u, r.end_u);
    p.v = blend_axis(factor, r.start_v, r.end_v);
    return p;
  endfunction

  task automatic queue_req(ease_kind_e k, int t, int su, int sv, int eu, int ev);
    ease_req_t r;
    r.kind = k;
    r.progress = TimeW'(t);
    r.start_u = PosW'(su);
    r.start_v = PosW'(sv);
    r.end_u = PosW'(eu);
    r.end_v = PosW'(ev);
    req_backlog.push_back(r);
  endtask

  // Progress values cluster around segment edges, the midpoint and one.
  function automatic logic [TimeW-1:0] rand_progress();
    int edge_pts[8] = '{0, 23832, 47663, 59579, 65536, 32768, 20852, 44684};
    int pick;
    int t;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      t = $urandom_range(0, 65536);
    end else if (pick < 75) begin
      t = edge_pts[$urandom_range(0, 7)] + int'($urandom_range(0, 6)) - 3;
      if (t < 0) t = 0;
    end else if (pick < 88) begin
      t = $urandom_range(65537, 131071);
    end else begin
      t = $urandom_range(0, 131071);
    end
    return TimeW'(t);
  endfunction

  function automatic logic signed [PosW-1:0] rand_position();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: begin
        case ($urandom_range(0, 3))
          0: return 24'sh7FFFFF;
          1: return 24'sh800000;
          2: return 24'sh000000;
          default: return 24'shFFFFFF;
        endcase
      end
      1, 2: begin
        return PosW'(int'($urandom_range(0, 1023)) - 512);
      end
      default: begin
        return PosW'($urandom);
      end
    endcase
  endfunction

  task automatic check_axis(string name, logic signed [PosW-1:0] want,
                            logic signed [PosW-1:0] got);
    if (want !== got) begin
      error_cnt++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Request driver: holds a request until it is taken, then picks the next
  // one unless the sender idles or waits for the pipeline to empty.
  always @(negedge clk_i) begin
    bit calm;
    bit drain_hold;
    bit next_valid;
    calm = (accepted_cnt >= CalmStart) && (accepted_cnt < CalmEnd);
    drain_hold = ((accepted_cnt == DrainFirst) || (accepted_cnt == DrainSecond)) &&
                 (pos_expected.size() != 0);
    if (rst_ni) begin
      if (!in_valid_i || req_taken) begin
        next_valid = 1'b0;
        if (req_backlog.size() > 0 && !drain_hold &&
            (calm || $urandom_range(0, 99) >= 32)) begin
          cur_req <= req_backlog.pop_front();
          next_valid = 1'b1;
        end
        in_valid_i <= next_valid;
      end
      out_ready_i <= calm || ($urandom_range(0, 99) >= 32);
    end
  end

  // Result monitor and request bookkeeping, sampled at the rising edge.
  always @(posedge clk_i) begin
    ease_pos_t want;
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
      $display("Regression FAIL");
      $finish;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (pos_expected.size() == 0) begin
          error_cnt++;
          $display("%0t: result with no request pending, actual u %0d v %0d",
                   $time, pos_u_o, pos_v_o);
        end else begin
          want = pos_expected.pop_front();
          check_axis("pos_u", want.u, pos_u_o);
          check_axis("pos_v", want.v, pos_v_o);
          checked_cnt++;
        end
      end
      req_taken = in_valid_i && in_ready_o;
      if (req_taken) begin
        pos_expected.push_back(predict_position(cur_req));
        accepted_cnt++;
        if (cur_req.kind == KindOut) out_kind_cnt++;
        else inout_kind_cnt++;
        if (cur_req.progress > OneQ16) clipped_time_cnt++;
      end
    end
  end

  initial begin
    // Directed requests: segment edges, both modes, saturated time,
    // extreme endpoints and rounding ties.
    queue_req(KindOut, 0, 0, 0, 256, -256);
    queue_req(KindOut, 65536, -8388608, 8388607, 8388607, -8388608);
    queue_req(KindOut, 131071, 100, -100, 8388607, -8388608);
    queue_req(KindOut, 23831, -5000, 7000, 90000, -33000);
    queue_req(KindOut, 23832, -5000, 7000, 90000, -33000);
    queue_req(KindOut, 47662, 1234, -4321, -777777, 555555);
    queue_req(KindOut, 47663, 1234, -4321, -777777, 555555);
    queue_req(KindOut, 59578, -8388608, 8388607, 8388607, -8388608);
    queue_req(KindOut, 59579, -8388608, 8388607, 8388607, -8388608);
    queue_req(KindInOut, 0, 300, -300, -8388608, 8388607);
    queue_req(KindInOut, 32767, -8388608, 8388607, 8388607, -8388608);
    queue_req(KindInOut, 32768, 0, 0, 1, -1);
    queue_req(KindInOut, 32768, -8388608, 8388607, 8388607, -8388608);
    queue_req(KindInOut, 65536, 42, -42, 8388607, -8388608);
    queue_req(KindInOut, 65537, 42, -42, -1000, 1000);
    queue_req(KindInOut, 131071, 8388607, -8388608, 0, 0);
    queue_req(KindInOut, 20852, -65536, 65536, 65536, -65536);
    queue_req(KindInOut, 20851, -65536, 65536, 65536, -65536);
    queue_req(KindInOut, 44684, 777, 888, -999, 111);
    queue_req(KindInOut, 44683, 777, 888, -999, 111);
    queue_req(KindOut, 98304, 8388607, -8388608, 8388607, -8388608);

    // Random requests.
    for (int i = 0; i < RandomReqs; i++) begin
      ease_req_t r;
      r.kind = ease_kind_e'($urandom_range(0, 1));
      r.progress = rand_progress();
      r.start_u = rand_position();
      r.start_v = rand_position();
      r.end_u = rand_position();
      r.end_v = rand_position();
      req_backlog.push_back(r);
    end
    total_reqs = req_backlog.size();

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (accepted_cnt == total_reqs && pos_expected.size() == 0);
    repeat (DrainLatency) @(posedge clk_i);

    $display("Checked %0d positions from %0d requests (%0d ease-out, %0d in-out).",
             checked_cnt, accepted_cnt, out_kind_cnt, inout_kind_cnt);
    $display("%0d requests had progress past one; %0d errors seen.",
             clipped_time_cnt, error_cnt);
    if (error_cnt == 0 && pos_expected.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
